// ===== src/mld_pkg.sv =====
// Shared constants, types and the A to Z Morse table for the light decoder.
// No dependencies; every other file imports this package.
package mld_pkg;

	localparam int MAX_SYMBOLS = 9;
	localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
	localparam int SAMPLE_W = 12;
	localparam int TICK_W = 16;
	localparam int LETTER_W = 7;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int LETTER_COUNT = 26;

	localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DASH_LIMIT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAP_LIMIT = 2'd2;

	localparam logic [SAMPLE_W-1:0] LEVEL_THRESHOLD_RST = 12'd2048;
	localparam logic [TICK_W-1:0] DASH_LIMIT_RST = 16'd5;
	localparam logic [TICK_W-1:0] GAP_LIMIT_RST = 16'd5;

	localparam logic [LETTER_W-1:0] LETTER_A = 7'd65;
	localparam logic [LETTER_W-1:0] NO_MATCH_CODE = 7'd95;

	typedef struct packed {
		logic [SAMPLE_W-1:0] level_threshold;
		logic [TICK_W-1:0] dash_limit_ticks;
		logic [TICK_W-1:0] gap_limit_ticks;
	} mld_cfg_t;

	// Symbol sequence handed from the tracker to the table lookup
	typedef struct packed {
		logic fire;
		logic [CNT_W-1:0] count;
		logic [MAX_SYMBOLS-1:0] marks;
		logic overflow;
	} mld_held_t;

	typedef struct packed {
		logic [2:0] len;
		logic [3:0] dashes;
	} mld_entry_t;

	// Length and dash bits (bit i set when symbol i is a dash) for A to Z
	localparam mld_entry_t LETTER_TABLE [LETTER_COUNT] = '{
		'{3'd2, 4'd2}, '{3'd4, 4'd1}, '{3'd4, 4'd5}, '{3'd3, 4'd1},
		'{3'd1, 4'd0}, '{3'd4, 4'd4}, '{3'd3, 4'd3}, '{3'd4, 4'd0},
		'{3'd2, 4'd0}, '{3'd4, 4'd14}, '{3'd3, 4'd5}, '{3'd4, 4'd2},
		'{3'd2, 4'd3}, '{3'd2, 4'd1}, '{3'd3, 4'd7}, '{3'd4, 4'd6},
		'{3'd4, 4'd11}, '{3'd3, 4'd2}, '{3'd3, 4'd0}, '{3'd1, 4'd1},
		'{3'd3, 4'd4}, '{3'd4, 4'd8}, '{3'd3, 4'd6}, '{3'd4, 4'd9},
		'{3'd4, 4'd13}, '{3'd4, 4'd3}
	};

endpackage

// ===== src/mld_tracker.sv =====
// Edge tracker: light state, tick counter and the symbol buffer.
// Depends on mld_pkg; reports a finished character to the lookup.
module mld_tracker (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [mld_pkg::SAMPLE_W-1:0] sample,
	input  mld_pkg::mld_cfg_t cfg,
	output mld_pkg::mld_held_t held
);
	import mld_pkg::*;

	logic light_q;
	logic [TICK_W-1:0] ticks_q;
	logic [MAX_SYMBOLS-1:0] marks_q;
	logic [CNT_W-1:0] count_q;
	logic overflow_q;

	logic [TICK_W-1:0] elapsed;
	logic on_now;
	logic buf_full;
	logic gap_done;

	always_comb begin
		elapsed = (ticks_q != {TICK_W{1'b1}}) ? ticks_q + TICK_W'(1) : ticks_q;
		on_now = (sample >= cfg.level_threshold);
		buf_full = (count_q >= CNT_W'(MAX_SYMBOLS));
		gap_done = !on_now && !light_q && (elapsed > cfg.gap_limit_ticks) &&
			(count_q != '0);
		held.fire = gap_done;
		held.count = count_q;
		held.marks = marks_q;
		held.overflow = overflow_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q <= 1'b0;
			ticks_q <= '0;
			marks_q <= '0;
			count_q <= '0;
			overflow_q <= 1'b0;
		end else if (step) begin
			if (on_now) begin
				light_q <= 1'b1;
				ticks_q <= light_q ? elapsed : '0;
			end else if (light_q) begin
				// falling edge: classify the on time and append
				light_q <= 1'b0;
				ticks_q <= '0;
				if (!buf_full) begin
					if (elapsed > cfg.dash_limit_ticks) begin
						marks_q <= marks_q | (MAX_SYMBOLS'(1) << count_q);
					end
					count_q <= count_q + CNT_W'(1);
				end else begin
					overflow_q <= 1'b1;
				end
			end else begin
				ticks_q <= elapsed;
				if (gap_done) begin
					marks_q <= '0;
					count_q <= '0;
					overflow_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== src/mld_lookup.sv =====
// Table match of a held symbol sequence against the A to Z Morse codes.
// Depends on mld_pkg for the table and the held-sequence type.
module mld_lookup (
	input  mld_pkg::mld_held_t held,
	output logic [mld_pkg::LETTER_W-1:0] letter,
	output logic no_match
);
	import mld_pkg::*;

	logic found;
	logic [LETTER_W-1:0] code;

	always_comb begin
		found = 1'b0;
		code = NO_MATCH_CODE;
		for (int i = 0; i < LETTER_COUNT; i++) begin
			if (!found && (CNT_W'(LETTER_TABLE[i].len) == held.count) &&
				(MAX_SYMBOLS'(LETTER_TABLE[i].dashes) == held.marks)) begin
				found = 1'b1;
				code = LETTER_A + LETTER_W'(i);
			end
		end
		// an overrun sequence never matches
		if (held.overflow) begin
			found = 1'b0;
			code = NO_MATCH_CODE;
		end
		letter = code;
		no_match = !found;
	end

endmodule

// ===== src/morse_light_decoder_unit.sv =====
// Top level of the light-driven Morse decoder: input stage, config registers,
// result register. Depends on mld_pkg, mld_tracker and mld_lookup.
//
// Usage:
//   Input channel (in_valid/in_ready/sample): one sensor reading per tick.
//   Output channel (out_valid/out_ready/letter/no_match): one result per
//   finished character, 'A'..'Z' or '_' with no_match set.
//   Config port (cfg_we/cfg_index/cfg_data): 0 level threshold, 1 dash limit,
//   2 gap limit; write only while the block is idle.
// Path: a transferred sample waits in the input register until it advances
// through tracker and table match; a result it ends loads the result register.
// Throughput: one sample per cycle unless a waiting result stalls it; the input
// register feeds tracker and table match, the result register holds the letter.
// Reset: clears the light state, tick counter, symbol buffer and both
// pipeline valids; registers return to 2048, 5 and 5.
// Stall: while a result waits, the input register still takes a sample; the
// block stops taking samples only when that register is full and the waiting
// result blocks it from advancing.
module morse_light_decoder_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [mld_pkg::SAMPLE_W-1:0] sample,
	output logic out_valid,
	input  logic out_ready,
	output logic [mld_pkg::LETTER_W-1:0] letter,
	output logic no_match,
	input  logic cfg_we,
	input  logic [mld_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mld_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mld_pkg::*;

	mld_cfg_t cfg_q;
	logic valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic out_valid_q;
	logic [LETTER_W-1:0] letter_q;
	logic no_match_q;

	logic advance;
	mld_held_t held;
	logic [LETTER_W-1:0] look_letter;
	logic look_no_match;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign letter = letter_q;
	assign no_match = no_match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_threshold <= LEVEL_THRESHOLD_RST;
			cfg_q.dash_limit_ticks <= DASH_LIMIT_RST;
			cfg_q.gap_limit_ticks <= GAP_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEVEL_THRESHOLD: cfg_q.level_threshold <= cfg_data[SAMPLE_W-1:0];
				REG_DASH_LIMIT: cfg_q.dash_limit_ticks <= cfg_data[TICK_W-1:0];
				REG_GAP_LIMIT: cfg_q.gap_limit_ticks <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= sample;
		end
	end

	mld_tracker u_tracker (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.sample(sample_s1),
		.cfg(cfg_q),
		.held(held)
	);

	mld_lookup u_lookup (
		.held(held),
		.letter(look_letter),
		.no_match(look_no_match)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && held.fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && held.fire) begin
			letter_q <= look_letter;
			no_match_q <= look_no_match;
		end
	end

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

	a_match_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !no_match_q) |-> (letter_q >= LETTER_A &&
		letter_q <= LETTER_A + LETTER_W'(LETTER_COUNT - 1)))
		else $error("matched letter outside A to Z");

	a_miss_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && no_match_q) |-> (letter_q == NO_MATCH_CODE))
		else $error("no-match result without underscore code");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held.count <= CNT_W'(MAX_SYMBOLS))
		else $error("symbol count beyond buffer");
`endif

endmodule
